// ----- src/sit_pkg.sv -----
// sit_pkg: shared types and constants for the sector interleave timing block.
// No dependencies; imported by the controller, datapath and top level.
package sit_pkg;

    // Timing math, Q0.16 fractions of one revolution
    localparam int QUO_W      = 16;
    localparam int DIV_CNT_W  = 4;
    localparam int SKEW_MUL_W = 13;
    localparam logic [QUO_W-1:0]      SPAN_Q16       = 16'd64225;  // 0.98
    localparam logic [SKEW_MUL_W-1:0] SKEW_PER_TRACK = 13'd5243;   // 0.08

    // floor(x/18) == (x * DIV18_RECIP) >> DIV18_SHIFT for x < 2**21
    localparam logic [17:0] DIV18_RECIP = 18'd233017;
    localparam int          DIV18_SHIFT = 22;

    // Slot map tags: a slot is taken when its tag equals the current track tag
    localparam int EPOCH_W = 8;

    // Configuration register map (index = paddr[3:2])
    localparam logic [1:0] REG_SPT   = 2'd0;
    localparam logic [1:0] REG_CLASS = 2'd1;
    localparam logic [1:0] REG_MODE  = 2'd2;

    localparam logic [8:0] SPT_RESET = 9'd18;

    // interleave_mode codes
    localparam logic [1:0] MODE_AUTO   = 2'd0;
    localparam logic [1:0] MODE_FORCED = 2'd1;
    localparam logic [1:0] MODE_NONE   = 2'd2;
    localparam logic [1:0] MODE_DDHS   = 2'd3;

    // size_class codes
    localparam logic [1:0] CLASS_128 = 2'd0;
    localparam logic [1:0] CLASS_256 = 2'd1;

    typedef struct packed {
        logic start;       // item accepted this cycle
        logic clear_step;  // zero one slot map tag
        logic scan_step;   // advance free-slot scan
        logic mul;         // register 0.98 * slot
        logic div_load;    // seed serial divider
        logic div_step;    // one quotient bit
        logic commit;      // write result, mark slot, advance pointer
    } sit_cmd_t;

    typedef struct packed {
        logic need_clear;  // track start with the tag about to wrap
        logic clear_done;  // last tag of the clearing pass
        logic scan_done;
        logic out_free;
    } sit_sts_t;

endpackage

// ----- src/sit_if.sv -----
// sit_if: valid/ready channel interfaces for request and result beats.
// Depends on nothing; used by the top level.
interface sit_req_if;
    logic       valid;
    logic       ready;
    logic       restart;
    logic [6:0] track_number;

    modport source (output valid, output restart, output track_number, input ready);
    modport sink   (input valid, input restart, input track_number, output ready);
endinterface

interface sit_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  logical_sector;
    logic [7:0]  physical_slot;
    logic [15:0] timing_fraction;
    logic        last_sector;

    modport source (output valid, output logical_sector, output physical_slot,
                    output timing_fraction, output last_sector, input ready);
    modport sink   (input valid, input logical_sector, input physical_slot,
                    input timing_fraction, input last_sector, output ready);
endinterface

// ----- src/sit_ctrl.sv -----
// sit_ctrl: sequencer for one request: tag clear, scan, multiply, serial divide, commit.
// Depends on sit_pkg; drives sit_dp through sit_cmd_t.
module sit_ctrl
    import sit_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sit_sts_t sts,
    output sit_cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;
    localparam logic [2:0] S_CLEAR = 3'd6;
    localparam logic [2:0] S_INIT  = 3'd7;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    logic [2:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                // slot map tags cleared once after reset
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sts.need_clear ? S_CLEAR : S_SCAN;
                end
            end
            S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                    state_next = S_MUL;
                else
                    cmd.scan_step = 1'b1;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- src/sit_dp.sv -----
// sit_dp: slot map, free-slot scan, timing multiply, serial divider, output register.
// Depends on sit_pkg; commanded by sit_ctrl.
module sit_dp
    import sit_pkg::*;
#(
    parameter int MAX_SECTORS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  sit_cmd_t    cmd,
    output sit_sts_t    sts,
    input  logic [8:0]  cfg_spt,
    input  logic [1:0]  cfg_class,
    input  logic [1:0]  cfg_mode,
    input  logic        in_restart,
    input  logic [6:0]  in_track,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [7:0]  out_logical,
    output logic [7:0]  out_slot,
    output logic [15:0] out_timing,
    output logic        out_last
);

    localparam int SLOT_W = $clog2(MAX_SECTORS);
    localparam int CNT_W  = $clog2(MAX_SECTORS + 1);
    localparam int PROD_W = QUO_W + SLOT_W;

    // slot map: tag per slot, registered read
    logic [EPOCH_W-1:0] tag_mem [MAX_SECTORS];
    logic [EPOCH_W-1:0] tag_q;
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [EPOCH_W-1:0] mem_wdata;
    logic               mem_we;

    // control state
    logic [EPOCH_W-1:0]     epoch_reg;
    logic [SLOT_W-1:0]      clr_addr_reg;
    logic [SLOT_W-1:0]      next_slot_reg;
    logic [CNT_W-1:0]       done_reg;
    logic [QUO_W-1:0]       skew_reg;
    logic [CNT_W-1:0]       step_reg, step_next;
    logic                   out_valid_reg;

    // working registers
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  low_reg;
    logic [7:0]        logical_reg;
    logic [7:0]        pslot_reg;
    logic [15:0]       timing_reg;
    logic              last_reg;

    logic [CNT_W-1:0]  count;
    logic              skew_en;
    logic              restart_cond;
    logic              clear_done;
    logic              taken;
    logic [CNT_W:0]    half;
    logic [13:0]       cls1_num;
    logic [31:0]       cls1_prod;
    logic [CNT_W-1:0]  slot_inc;
    logic [SLOT_W-1:0] slot_wrap;
    logic [SLOT_W-1:0] slot_first;
    logic [CNT_W:0]    adv_sum;
    logic [CNT_W:0]    adv;
    logic [CNT_W:0]    trial;
    logic [19:0]       skew_prod;

    // effective sector count: zero reads as one, saturate at MAX_SECTORS
    always_comb
    begin
        priority if (cfg_spt == '0)
            count = CNT_W'(1);
        else if (32'(cfg_spt) > MAX_SECTORS)
            count = CNT_W'(MAX_SECTORS);
        else
            count = CNT_W'(cfg_spt);
    end

    always_comb
    begin
        priority if (cfg_mode == MODE_NONE)
            skew_en = 1'b0;
        else if (cfg_mode == MODE_DDHS)
            skew_en = 1'b1;
        else
            skew_en = (cfg_class == CLASS_128) || (cfg_class == CLASS_256);
    end

    // interleave step; class 1 uses ceil-ish 15/18 via reciprocal multiply
    assign half      = ({1'b0, count} + 1'b1) >> 1;
    assign cls1_num  = 14'(32'(count) * 32'd15 + 32'd17);
    assign cls1_prod = 32'(cls1_num) * 32'(DIV18_RECIP);

    always_comb
    begin
        priority if (cfg_mode == MODE_NONE)
            step_next = CNT_W'(1);
        else if (cfg_mode == MODE_DDHS)
            step_next = CNT_W'(half);
        else if (cfg_class == CLASS_128)
            step_next = CNT_W'(half);
        else if (cfg_class == CLASS_256)
            step_next = CNT_W'(cls1_prod >> DIV18_SHIFT);
        else
            step_next = CNT_W'(1);
    end

    assign restart_cond = in_restart || (done_reg >= count);
    assign skew_prod    = 20'(in_track) * 20'(SKEW_PER_TRACK);

    assign slot_first = restart_cond ? '0
                      : ((CNT_W'(next_slot_reg) >= count) ? '0 : next_slot_reg);
    assign slot_inc   = CNT_W'(slot_reg) + 1'b1;
    assign slot_wrap  = (slot_inc >= count) ? '0 : SLOT_W'(slot_inc);

    assign adv_sum = {1'b0, CNT_W'(slot_reg)} + {1'b0, step_reg};
    assign adv     = (adv_sum >= {1'b0, count}) ? adv_sum - {1'b0, count} : adv_sum;

    assign trial = {rem_reg, low_reg[QUO_W-1]};

    // tag_q holds the tag of slot_reg during the scan
    assign taken      = (tag_q == epoch_reg);
    assign clear_done = (clr_addr_reg == SLOT_W'(MAX_SECTORS - 1));

    // read the first slot at accept, then one slot ahead of the check
    always_comb
    begin
        priority if (cmd.start)
            rd_addr = slot_first;
        else if (cmd.scan_step)
            rd_addr = slot_wrap;
        else
            rd_addr = slot_reg;
    end

    assign mem_we    = cmd.commit || cmd.clear_step;
    assign mem_waddr = cmd.clear_step ? clr_addr_reg : slot_reg;
    assign mem_wdata = cmd.clear_step ? '0 : epoch_reg;

    assign sts.need_clear = restart_cond && (epoch_reg == '1);
    assign sts.clear_done = clear_done;
    assign sts.scan_done  = !((n_reg < count) && taken);
    assign sts.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tag_mem[mem_waddr] <= mem_wdata;
        tag_q <= tag_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg     <= EPOCH_W'(1);
            clr_addr_reg  <= '0;
            next_slot_reg <= '0;
            done_reg      <= '0;
            skew_reg      <= '0;
            step_reg      <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            // new track: a fresh tag frees every slot; tag wrap runs a clearing pass
            if (cmd.start && restart_cond)
            begin
                epoch_reg     <= (epoch_reg == '1) ? EPOCH_W'(1) : epoch_reg + 1'b1;
                next_slot_reg <= '0;
                done_reg      <= '0;
                skew_reg      <= skew_en ? skew_prod[QUO_W-1:0] : '0;
            end
            if (cmd.clear_step)
                clr_addr_reg <= clear_done ? '0 : clr_addr_reg + 1'b1;
            if (cmd.commit)
            begin
                done_reg      <= done_reg + 1'b1;
                next_slot_reg <= SLOT_W'(adv);
            end
            priority if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            slot_reg <= slot_first;
            n_reg    <= '0;
        end
        if (cmd.scan_step)
        begin
            slot_reg <= slot_wrap;
            n_reg    <= n_reg + 1'b1;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(SPAN_Q16) * PROD_W'(slot_reg);
        if (cmd.div_load)
        begin
            rem_reg <= CNT_W'(prod_reg[PROD_W-1:QUO_W]);
            low_reg <= prod_reg[QUO_W-1:0];
        end
        if (cmd.div_step)
        begin
            if (trial >= {1'b0, count})
            begin
                rem_reg <= CNT_W'(trial - {1'b0, count});
                low_reg <= {low_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= CNT_W'(trial);
                low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.commit)
        begin
            logical_reg <= 8'(done_reg);
            pslot_reg   <= 8'(slot_reg);
            timing_reg  <= skew_reg + low_reg;
            last_reg    <= ((done_reg + 1'b1) == count);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_logical = logical_reg;
    assign out_slot    = pslot_reg;
    assign out_timing  = timing_reg;
    assign out_last    = last_reg;

endmodule

// ----- src/sector_interleave_timing.sv -----
// sector_interleave_timing: top level; APB configuration registers, sequencer, datapath.
// Depends on sit_pkg, sit_if, sit_ctrl and sit_dp.
//
// Usage:
//   req (sink): one beat per logical sector. restart=1 starts a new track and
//     latches the track skew; a beat after the track's last sector does the same.
//   rsp (source): one beat per request with the logical sector index, the
//     physical slot picked by the greedy interleave, its start angle as a Q0.16
//     fraction of a revolution, and a last-sector flag.
//   APB: sectors_per_track at 0x0, size_class at 0x4, interleave_mode at 0x8.
//     Write only while no request is in flight.
// Sequence: accept, then the scan, which steps over occupied slots one per cycle
//   until it hits a free slot, then multiply, divider load, the serial restoring
//   divide and commit; the next request is accepted only after the commit. Every
//   255th track start first runs a pass that clears the slot map tags.
// Reset: pointer, counter and skew clear; registers take 18 sectors, 128-byte
//   class, auto mode; req.ready stays low while the slot map tags are cleared.
// Stall: a finished result sits in the rsp register; the next request is still
//   accepted and worked on, and its commit waits until the register drains.
module sector_interleave_timing
    import sit_pkg::*;
#(
    parameter int MAX_SECTORS = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    sit_req_if.sink     req,
    sit_rsp_if.source   rsp
);

    logic [8:0] spt_reg;
    logic [1:0] class_reg;
    logic [1:0] mode_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    sit_cmd_t cmd;
    sit_sts_t sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // config registers; writes to unmapped addresses are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg   <= SPT_RESET;
            class_reg <= CLASS_128;
            mode_reg  <= MODE_AUTO;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_SPT:   spt_reg   <= pwdata[8:0];
                REG_CLASS: class_reg <= pwdata[1:0];
                REG_MODE:  mode_reg  <= pwdata[1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SPT:   prdata = 32'(spt_reg);
            REG_CLASS: prdata = 32'(class_reg);
            REG_MODE:  prdata = 32'(mode_reg);
            default:   prdata = '0;
        endcase
    end

    // sequencer: owns req.ready (high only between requests)
    sit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: slot map, scan, timing arithmetic and the rsp output register
    sit_dp #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_spt     (spt_reg),
        .cfg_class   (class_reg),
        .cfg_mode    (mode_reg),
        .in_restart  (req.restart),
        .in_track    (req.track_number),
        .out_ready   (rsp.ready),
        .out_valid   (rsp.valid),
        .out_logical (rsp.logical_sector),
        .out_slot    (rsp.physical_slot),
        .out_timing  (rsp.timing_fraction),
        .out_last    (rsp.last_sector)
    );

endmodule
